>>> hw/rtl/bspg_pkg.sv
package bspg_pkg;

   // Default channel layout
   localparam int DEF_SERVOS_PER_BANK = 4;
   localparam int DEF_BANK_COUNT      = 2;

   // Field widths
   localparam int CHAN_W   = 4;
   localparam int NS_W     = 25;
   localparam int WIDTH_W  = 16;
   localparam int PINS_W   = 8;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 16;

   // Response tdata bit positions
   localparam int RSP_BANK_BIT    = PINS_W;
   localparam int RSP_STARTED_BIT = PINS_W + 1;

   // Timing constants
   localparam int NS_PER_COUNT  = 500;
   localparam int CENTER_COUNTS = 3000;
   localparam int FRAME_RESET   = 16000;

   // Divide by 500 as a shift by 2, then a reciprocal multiply for 125
   localparam int PRE_SHIFT   = 2;
   localparam int DIV_REST    = NS_PER_COUNT / (2 ** PRE_SHIFT);
   localparam int RECIP_SHIFT = 30;
   localparam longint RECIP_MULT = ((64'd1 << RECIP_SHIFT) + DIV_REST - 1) / DIV_REST;
   localparam int DIV_IN_W    = NS_W - PRE_SHIFT;
   localparam int RECIP_W     = 24;
   localparam int PROD_W      = DIV_IN_W + RECIP_W;

   // Register map
   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_FRAME = 1'b0;

   // Request kinds
   typedef enum logic {
      REQ_TICK  = 1'b0,
      REQ_WRITE = 1'b1
   } req_kind_type;

endpackage

>>> hw/rtl/banked_servo_pulse_generator.sv
// A request is held in the input register, then its response in the response register.
// Throughput: one request per cycle while the response is not stalled; the two registers
// form a two-stage pipeline and the whole state update sits between them.
// Reset (synchronous, active high): every stored width is 3000 counts, frame length
// 16000 ticks, generator stopped with all pins low, bank 0, both stages empty.
module banked_servo_pulse_generator #(
   parameter int SERVOS_PER_BANK = bspg_pkg::DEF_SERVOS_PER_BANK,
   parameter int BANK_COUNT      = bspg_pkg::DEF_BANK_COUNT
) (
   input  logic                            clock,
   input  logic                            reset,
   // request stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // tdata: channel [3:0], width_ns [28:4], zero [31:29]
   input  logic [bspg_pkg::REQ_DATA_W-1:0] req_tdata,
   // tuser: req_type [0]
   input  logic                            req_tuser,
   // response stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // tdata: servo_pins [7:0], active_bank [8], started [9], zero [15:10]
   output logic [bspg_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // configuration port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [bspg_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import bspg_pkg::*;

   localparam int TOTAL  = SERVOS_PER_BANK * BANK_COUNT;
   localparam int BANK_W = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;

   // Configuration
   logic [WIDTH_W-1:0] frame_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_FRAME) ? {16'b0, frame_ff} : 32'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= WIDTH_W'(FRAME_RESET);
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   (csr_paddr[2] == CSR_IDX_FRAME)) begin
         frame_ff <= csr_pwdata[WIDTH_W-1:0];
      end
   end

   // Pipeline handshake
   logic             in_valid_ff;
   req_kind_type     in_kind_ff;
   logic [CHAN_W-1:0] in_chan_ff;
   logic [NS_W-1:0]  in_ns_ff;
   logic             rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic             advance;
   logic             fire;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Generator state
   logic [WIDTH_W-1:0] width_ff [SERVOS_PER_BANK][BANK_COUNT];
   logic [WIDTH_W-1:0] latch_ff [SERVOS_PER_BANK];
   logic [WIDTH_W-1:0] latch_in [SERVOS_PER_BANK];
   logic [WIDTH_W-1:0] pos_ff, pos_in;
   logic [BANK_W-1:0]  bank_ff, bank_in;
   logic               run_ff, run_in;
   logic [PINS_W-1:0]  pins_ff, pins_in;

   // Nanoseconds to counts: floor(ns / 500) saturated to 16 bits
   logic [DIV_IN_W-1:0] div_in;
   logic [PROD_W-1:0]   prod;
   logic [16:0]         quot;
   logic [WIDTH_W-1:0]  wr_width;

   assign div_in   = in_ns_ff[NS_W-1:PRE_SHIFT];
   assign prod     = PROD_W'(div_in) * PROD_W'(RECIP_MULT);
   assign quot     = prod[RECIP_SHIFT+16:RECIP_SHIFT];
   assign wr_width = quot[16] ? {WIDTH_W{1'b1}} : quot[WIDTH_W-1:0];

   logic        chan_ok;
   logic        is_write;
   logic [16:0] next_pos;
   logic [PINS_W-1:0] lane_mask [SERVOS_PER_BANK];

   assign chan_ok  = 6'(in_chan_ff) < 6'(TOTAL);
   assign is_write = (in_kind_ff == REQ_WRITE);
   assign next_pos = {1'b0, pos_ff} + 17'd1;

   // Output bit of each lane in the active bank; servos past the eighth are not shown
   always_comb begin
      logic [5:0] srv;
      for (int i = 0; i < SERVOS_PER_BANK; i++) begin
         srv = 6'(bank_ff) * 6'(SERVOS_PER_BANK) + 6'(i);
         lane_mask[i] = (srv < 6'(PINS_W)) ? (PINS_W'(1) << srv[2:0]) : '0;
      end
   end

   // Next state for the request in the input register
   always_comb begin
      pins_in = pins_ff;
      pos_in  = pos_ff;
      bank_in = bank_ff;
      run_in  = run_ff;
      for (int i = 0; i < SERVOS_PER_BANK; i++) begin
         latch_in[i] = latch_ff[i];
      end
      if (is_write) begin
         if (chan_ok && !run_ff) begin
            run_in  = 1'b1;
            pins_in = '0;
            pos_in  = '0;
         end
      end else if (run_ff) begin
         if (pos_ff == '0) begin
            // frame start: latch the bank and raise nonzero pins
            pins_in = '0;
            for (int i = 0; i < SERVOS_PER_BANK; i++) begin
               latch_in[i] = width_ff[i][bank_ff];
               if (width_ff[i][bank_ff] != '0) begin
                  pins_in = pins_in | lane_mask[i];
               end
            end
         end else begin
            for (int i = 0; i < SERVOS_PER_BANK; i++) begin
               if (latch_ff[i] == pos_ff) begin
                  pins_in = pins_in & ~lane_mask[i];
               end
            end
         end
         // frame end: drop everything and move to the next bank
         if (next_pos >= {1'b0, frame_ff}) begin
            pins_in = '0;
            pos_in  = '0;
            bank_in = (bank_ff == BANK_W'(BANK_COUNT - 1)) ? '0 : bank_ff + BANK_W'(1);
         end else begin
            pos_in = next_pos[WIDTH_W-1:0];
         end
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_kind_ff <= req_kind_type'(req_tuser);
         in_chan_ff <= req_tdata[CHAN_W-1:0];
         in_ns_ff   <= req_tdata[CHAN_W+NS_W-1:CHAN_W];
      end
   end

   // Generator state update, one request per fired transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         bank_ff <= '0;
         run_ff  <= 1'b0;
         pins_ff <= '0;
         for (int i = 0; i < SERVOS_PER_BANK; i++) begin
            latch_ff[i] <= '0;
            for (int b = 0; b < BANK_COUNT; b++) begin
               width_ff[i][b] <= WIDTH_W'(CENTER_COUNTS);
            end
         end
      end else if (fire) begin
         pos_ff  <= pos_in;
         bank_ff <= bank_in;
         run_ff  <= run_in;
         pins_ff <= pins_in;
         for (int i = 0; i < SERVOS_PER_BANK; i++) begin
            latch_ff[i] <= latch_in[i];
            for (int b = 0; b < BANK_COUNT; b++) begin
               if (is_write && ({1'b0, in_chan_ff} == 5'(b * SERVOS_PER_BANK + i))) begin
                  width_ff[i][b] <= wr_width;
               end
            end
         end
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= {6'b0, run_in, bank_in[0], pins_in};
      end
   end

endmodule

>>> hw/rtl/bspg_checker.sv
module bspg_checker #(
   parameter int SERVOS_PER_BANK = bspg_pkg::DEF_SERVOS_PER_BANK,
   parameter int BANK_COUNT      = bspg_pkg::DEF_BANK_COUNT
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [bspg_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import bspg_pkg::*;

   logic              rsp_xfer;
   logic              seen_started_ff;
   logic [PINS_W-1:0] pins;
   logic [PINS_W-1:0] bank_mask;

   assign rsp_xfer = rsp_tvalid && rsp_tready;
   assign pins     = rsp_tdata[PINS_W-1:0];

   // Pins that may be high while the shown bank is being pulsed
   always_comb begin
      bank_mask = '0;
      for (int s = 0; s < PINS_W; s++) begin
         if (BANK_COUNT == 2 && (s / SERVOS_PER_BANK) < BANK_COUNT) begin
            bank_mask[s] = ((s / SERVOS_PER_BANK) % 2) == int'(rsp_tdata[RSP_BANK_BIT]);
         end else begin
            bank_mask[s] = 1'b1;
         end
      end
   end

   // Track whether a started response has been delivered
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_started_ff <= 1'b0;
      end else if (rsp_xfer && rsp_tdata[RSP_STARTED_BIT]) begin
         seen_started_ff <= 1'b1;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   a_started_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && seen_started_ff |-> rsp_tdata[RSP_STARTED_BIT])
      else $error("generator stopped after starting");

   a_idle_pins_low: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && !rsp_tdata[RSP_STARTED_BIT] |-> pins == '0)
      else $error("pin high before the first width write");

   a_bank_pins_only: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer |-> (pins & ~bank_mask) == '0)
      else $error("pin high outside the active bank");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

bind banked_servo_pulse_generator bspg_checker #(
   .SERVOS_PER_BANK(SERVOS_PER_BANK),
   .BANK_COUNT(BANK_COUNT)
) u_bspg_checker (.*);
